[src/bshm_pkg.sv]
`default_nettype none
package bshm_pkg;
  localparam int DEPTH_DEF = 1024;
  localparam logic [1:0] KIND_LOG = 2'd0;
  localparam logic [1:0] KIND_RD_IDX = 2'd1;
  localparam logic [1:0] KIND_RD_TIME = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SPAN = 2'd2;
  localparam logic [1:0] REG_LEN_LIMIT = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_UPPER = 2'd2;
  localparam logic signed [47:0] SAT_POS = 48'sh7FFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_TSRCH_RD, S_TSRCH, S_FETCH, S_FETCH_W,
    S_MUL, S_DIV, S_DIVDONE, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

[src/bounded_sample_history_minmax.sv]
// bounded sample history with running min and max
// input channel: in_valid/in_stall with kind, sample, timestamp, position;
// output channel: out_valid/out_stall, one result item per input item.
// config channel: cfg_valid/cfg_ready, cfg_index 0 length limit, 1 lower_range,
// 2 upper_range; the user must write them only while idle; the block itself
// does not enforce this. one item at a time. a log that drops entries
// rescans the kept entries through the store read port, one entry per cycle.
// a read by index uses the bit-serial divider for the percent scaling; a read
// by time adds a linear search over the held entries, each through the
// S_TSRCH_RD and S_TSRCH states.
// the result sits in an output register until taken; while the receiver
// stalls no new item is taken.
// reset empties the history, sets min to the largest and max to the most
// negative value, and restores register defaults. store contents are not
// cleared.
`default_nettype none
module bounded_sample_history_minmax #(
  parameter int DEPTH = bshm_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] kind,
  input  wire logic signed [31:0] sample,
  input  wire logic [31:0] timestamp,
  input  wire logic [9:0] position,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] status,
  output logic signed [31:0] entry_value,
  output logic [31:0] entry_time,
  output logic signed [47:0] scaled_value,
  output logic [10:0] entry_count,
  output logic signed [31:0] window_min,
  output logic signed [31:0] window_max,
  output logic signed [31:0] last_value,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  import bshm_pkg::*;

  state_t state, state_next;
  logic [10:0] len_limit;
  logic signed [31:0] lower_range, upper_range;
  logic [AW-1:0] oldest;
  logic [CW-1:0] held;
  logic signed [31:0] rmin, rmax, newest;
  logic [31:0] k_ts;
  logic [CW-1:0] k;
  logic signed [31:0] ev;
  logic [31:0] et;
  logic [1:0] st;
  logic neg;
  logic signed [63:0] num_s, den_s;
  logic [47:0] sc;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [31:0] rvalue;
  logic [31:0] rtime;
  div_req_t dreq;
  div_rsp_t drsp;

  bshm_store #(.DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wvalue(sample), .wtime(timestamp),
    .raddr(raddr), .rvalue(rvalue), .rtime(rtime)
  );
  bshm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // offset can reach DEPTH+1, so the wrap may be needed twice
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW:0] off);
    logic [CW+1:0] s;
    s = {{(CW+2-AW){1'b0}}, base} + {1'b0, off};
    if (s >= (CW+2)'(DEPTH)) s = s - (CW+2)'(DEPTH);
    if (s >= (CW+2)'(DEPTH)) s = s - (CW+2)'(DEPTH);
    return s[AW-1:0];
  endfunction

  logic [CW-1:0] limit;
  logic accept;
  logic [CW:0] cnt1, drop;
  logic evict, idx_hit, ts_more;
  logic signed [63:0] vdiff;
  assign limit = ({21'd0, len_limit} > DEPTH) ? CW'(DEPTH) : CW'(len_limit);
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign cfg_ready = 1'b1;
  assign we = accept && (kind == KIND_LOG);
  assign waddr = slot(oldest, (held < CW'(DEPTH)) ? {1'b0, held} : '0);
  assign raddr = slot(oldest, {1'b0, k});
  assign cnt1 = {1'b0, held} + (CW+1)'(1);
  assign evict = cnt1 > {1'b0, limit};
  assign drop = cnt1 - {1'b0, limit};
  assign idx_hit = {{(32-CW){1'b0}}, held} > {22'd0, position};
  assign ts_more = (k + CW'(1) < held) && (k_ts > rtime);
  assign vdiff = 64'(rvalue) - 64'(lower_range);

  // abs values for the divider
  logic [63:0] an, ad;
  assign an = num_s[63] ? 64'(-num_s) : 64'(num_s);
  assign ad = den_s[63] ? 64'(-den_s) : 64'(den_s);
  assign dreq.start = (state == S_MUL);
  assign dreq.num = an + (ad >> 1);
  assign dreq.den = ad;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_LOG: state_next = (evict && limit != '0) ? S_SCAN_RD : S_OUT;
            KIND_CLEAR: state_next = S_OUT;
            KIND_RD_IDX: state_next = idx_hit ? S_FETCH : S_OUT;
            default: state_next = (held != '0) ? S_TSRCH_RD : S_OUT;
          endcase
        end
      end
      S_SCAN_RD: state_next = S_SCAN;
      S_SCAN: if (k == held) state_next = S_OUT;
      S_TSRCH_RD: state_next = S_TSRCH;
      S_TSRCH: state_next = ts_more ? S_TSRCH_RD : S_FETCH;
      S_FETCH: state_next = S_FETCH_W;
      S_FETCH_W: state_next = S_MUL;
      S_MUL: state_next = (den_s == '0) ? S_OUT : S_DIV;
      S_DIV: if (drsp.done) state_next = S_DIVDONE;
      S_DIVDONE: state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      len_limit <= 11'd1024;
      lower_range <= 32'sd0;
      upper_range <= 32'sd100;
      oldest <= '0;
      held <= '0;
      rmin <= 32'sh7FFF_FFFF;
      rmax <= 32'sh8000_0000;
      newest <= 32'sd0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_LEN_LIMIT: len_limit <= cfg_data[10:0];
          REG_LOWER: lower_range <= cfg_data;
          REG_UPPER: upper_range <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            k_ts <= timestamp;
            ev <= '0;
            et <= '0;
            sc <= '0;
            st <= ST_OK;
            k <= '0;
            case (kind)
              KIND_LOG: begin
                newest <= sample;
                if (evict) begin
                  // drop oldest and rescan what is left
                  oldest <= slot(oldest, drop);
                  held <= limit;
                  rmin <= 32'sh7FFF_FFFF;
                  rmax <= 32'sh8000_0000;
                end else begin
                  held <= cnt1[CW-1:0];
                  if (sample > rmax) rmax <= sample;
                  if (sample < rmin) rmin <= sample;
                end
              end
              KIND_CLEAR: begin
                held <= '0;
                oldest <= '0;
              end
              KIND_RD_IDX: begin
                if (idx_hit) k <= CW'(position);
                else st <= ST_EMPTY;
              end
              default: begin
                if (held == '0) st <= ST_EMPTY;
              end
            endcase
          end
        end
        S_SCAN_RD: k <= k + CW'(1);
        S_SCAN: begin
          // read data arrives the cycle after its address
          if (rvalue > rmax) rmax <= rvalue;
          if (rvalue < rmin) rmin <= rvalue;
          if (k != held) k <= k + CW'(1);
        end
        S_TSRCH: begin
          if (ts_more) k <= k + CW'(1);
        end
        S_FETCH_W: begin
          ev <= rvalue;
          et <= rtime;
          // times 100 * 65536 as shifted adds
          num_s <= (vdiff <<< 22) + (vdiff <<< 21) + (vdiff <<< 18);
          den_s <= 64'(upper_range) - 64'(lower_range);
        end
        S_MUL: begin
          neg <= num_s[63] != den_s[63];
          if (den_s == '0) st <= ST_SPAN;
        end
        S_DIVDONE: begin
          if (neg) sc <= (drsp.quo >= 64'h8000_0000_0000) ? 48'h8000_0000_0000
                                                         : 48'(-drsp.quo);
          else sc <= (drsp.quo > 64'(SAT_POS)) ? SAT_POS : drsp.quo[47:0];
        end
        S_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // scan reaches S_OUT only after last sample absorbed
  assign status = st;
  assign entry_value = ev;
  assign entry_time = et;
  assign scaled_value = sc;
  assign entry_count = 11'(held);
  assign window_min = rmin;
  assign window_max = rmax;
  assign last_value = newest;
endmodule
`default_nettype wire

[src/bshm_div.sv]
`default_nettype none
module bshm_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire bshm_pkg::div_req_t req,
  output bshm_pkg::div_rsp_t rsp
);
  import bshm_pkg::*;
  logic [63:0] quo, rem_r, den;
  logic [6:0] cnt;
  logic busy, done;
  logic [64:0] trial;

  always_comb begin
    trial = {rem_r, quo[63]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.num;
        den <= req.den;
        rem_r <= '0;
        cnt <= 7'd64;
      end else if (busy) begin
        // one quotient bit per cycle, restoring
        if (!trial[64]) begin
          rem_r <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo = quo;
endmodule
`default_nettype wire

[src/bshm_store.sv]
`default_nettype none
module bshm_store #(
  parameter int DEPTH = bshm_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic signed [31:0] wvalue,
  input  wire logic [31:0] wtime,
  input  wire logic [AW-1:0] raddr,
  output logic signed [31:0] rvalue,
  output logic [31:0] rtime
);
  import bshm_pkg::*;
  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvalue, wtime};
    end
    {rvalue, rtime} <= mem[raddr];
  end
endmodule
`default_nettype wire

[tb/bounded_sample_history_minmax_tb.sv]
`default_nettype none
module bounded_sample_history_minmax_tb;
  import bshm_pkg::*;

  localparam int HIST_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int HOLD_CYCLES = 600;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int NUM_PHASES = 9;
  localparam int NUM_ROWS = 22;
  localparam int EXP_SLOTS = 64;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;
  localparam longint SAT_MAG48 = 64'sd140737488355328;

  typedef struct packed {
    logic [1:0] status;
    logic signed [31:0] entry_value;
    logic [31:0] entry_time;
    logic signed [47:0] scaled_value;
    logic [10:0] entry_count;
    logic signed [31:0] window_min;
    logic signed [31:0] window_max;
    logic signed [31:0] last_value;
  } hist_result_t;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [31:0] sample;
    logic [31:0] timestamp;
    logic [9:0] position;
  } hist_item_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] kind;
  logic signed [31:0] sample;
  logic [31:0] timestamp;
  logic [9:0] position;
  logic out_valid;
  logic out_stall;
  logic [1:0] status;
  logic signed [31:0] entry_value;
  logic [31:0] entry_time;
  logic signed [47:0] scaled_value;
  logic [10:0] entry_count;
  logic signed [31:0] window_min;
  logic signed [31:0] window_max;
  logic signed [31:0] last_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  bounded_sample_history_minmax u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .sample(sample), .timestamp(timestamp), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .entry_value(entry_value), .entry_time(entry_time),
    .scaled_value(scaled_value), .entry_count(entry_count),
    .window_min(window_min), .window_max(window_max), .last_value(last_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the history and its registers
  logic signed [31:0] value_mem [HIST_DEPTH];
  logic [31:0] time_mem [HIST_DEPTH];
  int unsigned head_ptr;
  int unsigned held;
  logic signed [31:0] track_min;
  logic signed [31:0] track_max;
  logic signed [31:0] newest;
  int unsigned limit_reg;
  logic signed [31:0] lower_reg;
  logic signed [31:0] upper_reg;

  hist_result_t exp_ring [EXP_SLOTS];
  int exp_wr;
  int exp_rd;
  int errors;
  int cycles;
  int tx_pct;
  int rx_pct;
  bit hold_req;
  bit hold_done;
  int hold_left;
  logic [31:0] time_now;
  hist_item_t rows [NUM_ROWS];
  bit row_typed [NUM_ROWS];
  hist_result_t row_exp [NUM_ROWS];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned slot_at(int unsigned k);
    return (head_ptr + k) % HIST_DEPTH;
  endfunction

  function automatic logic signed [47:0] percent_of_range(logic signed [31:0] v,
                                                          output bit zero_span);
    longint num, den, an, ad, q;
    bit neg;
    num = (longint'(v) - longint'(lower_reg)) * 64'sd6553600;
    den = longint'(upper_reg) - longint'(lower_reg);
    zero_span = (den == 0);
    if (zero_span) return '0;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (an + ad / 2) / ad;
    if (neg) return (q >= SAT_MAG48) ? 48'sh8000_0000_0000 : 48'(-q);
    return (q > SAT_MAG48 - 1) ? SAT_POS : 48'(q);
  endfunction

  function automatic hist_result_t history_step(hist_item_t it);
    hist_result_t r;
    int unsigned lim, s, k, cnt;
    bit found, zero_span;
    r = '0;
    case (it.kind)
      KIND_LOG: begin
        lim = (limit_reg > HIST_DEPTH) ? HIST_DEPTH : limit_reg;
        if (it.sample > track_max) track_max = it.sample;
        if (it.sample < track_min) track_min = it.sample;
        newest = it.sample;
        s = slot_at((held < HIST_DEPTH) ? held : 0);
        value_mem[s] = it.sample;
        time_mem[s] = it.timestamp;
        cnt = held + 1;
        if (cnt > lim) begin
          // eviction: drop the oldest and rescan what is left
          head_ptr = (head_ptr + cnt - lim) % HIST_DEPTH;
          held = lim;
          track_min = POS_MAX;
          track_max = NEG_MAX;
          for (k = 0; k < held; k++) begin
            if (value_mem[slot_at(k)] > track_max) track_max = value_mem[slot_at(k)];
            if (value_mem[slot_at(k)] < track_min) track_min = value_mem[slot_at(k)];
          end
        end else begin
          held = cnt;
        end
      end
      KIND_CLEAR: begin
        held = 0;
        head_ptr = 0;
      end
      default: begin
        found = 0;
        k = 0;
        if (it.kind == KIND_RD_IDX) begin
          if (it.position < held) begin
            k = it.position;
            found = 1;
          end
        end else if (held > 0) begin
          while (k + 1 < held && it.timestamp > time_mem[slot_at(k)]) k++;
          found = 1;
        end
        if (!found) begin
          r.status = ST_EMPTY;
        end else begin
          r.entry_value = value_mem[slot_at(k)];
          r.entry_time = time_mem[slot_at(k)];
          r.scaled_value = percent_of_range(r.entry_value, zero_span);
          r.status = zero_span ? ST_SPAN : ST_OK;
        end
      end
    endcase
    r.entry_count = 11'(held);
    r.window_min = track_min;
    r.window_max = track_max;
    r.last_value = newest;
    return r;
  endfunction

  function automatic hist_result_t idle_result(logic [1:0] st, int cnt,
                                               logic signed [31:0] mn,
                                               logic signed [31:0] mx,
                                               logic signed [31:0] lst);
    hist_result_t r;
    r = '0;
    r.status = st;
    r.entry_count = 11'(cnt);
    r.window_min = mn;
    r.window_max = mx;
    r.last_value = lst;
    return r;
  endfunction

  // output side: stall generator with a one-off long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  always @(posedge clk) begin
    hist_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, entry_value, entry_time, scaled_value, entry_count,
              window_min, window_max, last_value};
      if (exp_wr == exp_rd) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = exp_ring[exp_rd % EXP_SLOTS];
        exp_rd++;
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.entry_value !== want.entry_value) begin
          $error("entry_value exp %0d got %0d", want.entry_value, got.entry_value);
          errors++;
        end
        if (got.entry_time !== want.entry_time) begin
          $error("entry_time exp %0d got %0d", want.entry_time, got.entry_time);
          errors++;
        end
        if (got.scaled_value !== want.scaled_value) begin
          $error("scaled_value exp %0d got %0d", want.scaled_value, got.scaled_value);
          errors++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count exp %0d got %0d", want.entry_count, got.entry_count);
          errors++;
        end
        if (got.window_min !== want.window_min) begin
          $error("window_min exp %0d got %0d", want.window_min, got.window_min);
          errors++;
        end
        if (got.window_max !== want.window_max) begin
          $error("window_max exp %0d got %0d", want.window_max, got.window_max);
          errors++;
        end
        if (got.last_value !== want.last_value) begin
          $error("last_value exp %0d got %0d", want.last_value, got.last_value);
          errors++;
        end
      end
    end
  end

  // drive one item, optionally after an idle gap; called at a rising edge
  task automatic send_item(hist_item_t it, bit typed, hist_result_t typed_exp);
    int gap;
    hist_result_t r;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < tx_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    sample <= it.sample;
    timestamp <= it.timestamp;
    position <= it.position;
    do @(posedge clk); while (in_stall);
    r = history_step(it);
    exp_ring[exp_wr % EXP_SLOTS] = typed ? typed_exp : r;
    exp_wr++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LEN_LIMIT: limit_reg = data[10:0];
      REG_LOWER: lower_reg = data;
      REG_UPPER: upper_reg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return POS_MAX;
      1: return NEG_MAX;
      2, 3: return lower_reg + $signed($urandom_range(0, 200)) - 50;
      4: return upper_reg - $signed($urandom_range(0, 100));
      default: return $urandom;
    endcase
  endfunction

  function automatic hist_item_t random_item();
    hist_item_t it;
    int w;
    it.sample = pick_sample();
    it.position = 10'($urandom);
    w = $urandom_range(0, 99);
    time_now = time_now + $urandom_range(0, 6);
    it.timestamp = ($urandom_range(0, 19) == 0) ? $urandom : time_now;
    if (w < 50) begin
      it.kind = KIND_LOG;
    end else if (w < 75) begin
      it.kind = KIND_RD_IDX;
      if ($urandom_range(0, 9) < 8) it.position = 10'($urandom_range(0, held));
    end else if (w < 94) begin
      it.kind = KIND_RD_TIME;
      if ($urandom_range(0, 9) < 8) it.timestamp = time_now - $urandom_range(0, 60);
    end else begin
      it.kind = KIND_CLEAR;
    end
    return it;
  endfunction

  initial begin
    int p, i;
    int unsigned ph_limit [NUM_PHASES] = '{8, 1, 16, 2047, 1024, 4, 32, 0, 12};
    logic [31:0] ph_lower [NUM_PHASES] = '{0, -1000, 7, 32'h8000_0000, 32'h7FFF_FFFF,
                                           0, 0, 0, 0};
    logic [31:0] ph_upper [NUM_PHASES] = '{100, 1000, 7, 32'h7FFF_FFFF,
                                           32'h8000_0000, 0, 1, 100, 0};
    int ph_tx [NUM_PHASES] = '{0, 71, 0, 17, 0, 71, 17, 0, 0};
    int ph_rx [NUM_PHASES] = '{0, 0, 71, 17, 0, 0, 17, 71, 0};

    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_LOG;
    sample = '0;
    timestamp = '0;
    position = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LEN_LIMIT;
    cfg_data = '0;
    exp_wr = 0;
    exp_rd = 0;
    errors = 0;
    cycles = 0;
    tx_pct = 0;
    rx_pct = 0;
    hold_req = 1'b0;
    time_now = 32'd100;
    head_ptr = 0;
    held = 0;
    track_min = POS_MAX;
    track_max = NEG_MAX;
    newest = 0;
    limit_reg = 1024;
    lower_reg = 0;
    upper_reg = 100;
    for (i = 0; i < HIST_DEPTH; i++) begin
      value_mem[i] = '0;
      time_mem[i] = '0;
    end
    for (i = 0; i < NUM_ROWS; i++) begin
      row_typed[i] = 1'b0;
      row_exp[i] = '0;
    end

    // directed rows under the reset register values
    rows[0] = '{KIND_RD_IDX, 0, 0, 0};
    row_typed[0] = 1; row_exp[0] = idle_result(ST_EMPTY, 0, POS_MAX, NEG_MAX, 0);
    rows[1] = '{KIND_RD_TIME, 0, 32'hFFFF_FFFF, 0};
    row_typed[1] = 1; row_exp[1] = idle_result(ST_EMPTY, 0, POS_MAX, NEG_MAX, 0);
    rows[2] = '{KIND_CLEAR, 0, 0, 10'h3FF};
    row_typed[2] = 1; row_exp[2] = idle_result(ST_OK, 0, POS_MAX, NEG_MAX, 0);
    rows[3] = '{KIND_LOG, 100, 10, 0};
    row_typed[3] = 1; row_exp[3] = idle_result(ST_OK, 1, 100, 100, 100);
    rows[4] = '{KIND_RD_IDX, 0, 0, 0};
    row_typed[4] = 1; row_exp[4] = idle_result(ST_OK, 1, 100, 100, 100);
    row_exp[4].entry_value = 100; row_exp[4].entry_time = 10;
    row_exp[4].scaled_value = 48'sd6553600;
    rows[5] = '{KIND_LOG, NEG_MAX, 20, 0};
    rows[6] = '{KIND_LOG, POS_MAX, 32'hFFFF_FFFF, 0};
    rows[7] = '{KIND_LOG, 0, 0, 0};
    rows[8] = '{KIND_RD_IDX, 0, 0, 1};
    rows[9] = '{KIND_RD_IDX, 0, 0, 2};
    rows[10] = '{KIND_RD_IDX, 0, 0, 3};
    rows[11] = '{KIND_RD_IDX, 0, 0, 4};
    rows[12] = '{KIND_RD_IDX, 0, 0, 10'h3FF};
    rows[13] = '{KIND_RD_TIME, 0, 0, 0};
    rows[14] = '{KIND_RD_TIME, 0, 15, 0};
    rows[15] = '{KIND_RD_TIME, 0, 21, 0};
    rows[16] = '{KIND_RD_TIME, 0, 32'hFFFF_FFFF, 0};
    rows[17] = '{KIND_LOG, -5, 30, 10'h155};
    rows[18] = '{KIND_RD_IDX, 0, 0, 4};
    rows[19] = '{KIND_CLEAR, 0, 0, 0};
    rows[20] = '{KIND_RD_IDX, 0, 0, 0};
    rows[21] = '{KIND_RD_TIME, 0, 0, 0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NUM_ROWS; i++) send_item(rows[i], row_typed[i], row_exp[i]);
    wait_drained();

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        ph_lower[p] = $urandom;
        ph_upper[p] = $urandom;
      end
      write_reg(REG_LEN_LIMIT, ph_limit[p]);
      write_reg(REG_LOWER, ph_lower[p]);
      write_reg(REG_UPPER, ph_upper[p]);
      tx_pct = ph_tx[p];
      rx_pct = ph_rx[p];
      // the output holds off for a long stretch while items keep coming
      if (p == 4) hold_req = 1'b1;
      for (i = 0; i < ITEMS_PER_PHASE; i++) send_item(random_item(), 1'b0, '0);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
src/bshm_pkg.sv
src/bshm_div.sv
src/bshm_store.sv
src/bounded_sample_history_minmax.sv
tb/bounded_sample_history_minmax_tb.sv
